[hdl/sspc_pkg.sv]
package sspc_pkg;

  localparam logic [7:0] HDR_BYTE    = 8'hFF;
  localparam logic [7:0] BAD_ID      = 8'hFF;
  localparam logic [7:0] FILL_BYTE   = 8'hFF;
  localparam logic [8:0] LEN_EXTRA   = 9'd3;
  localparam logic [9:0] PKT_EXTRA   = 10'd4;
  localparam logic [8:0] POS_ID      = 9'd2;
  localparam logic [8:0] POS_LEN     = 9'd3;
  localparam logic [8:0] POS_STATUS  = 9'd4;

  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_HEADER   = 3'd1;
  localparam logic [2:0] ERR_ID_MISM  = 3'd2;
  localparam logic [2:0] ERR_ID_BCAST = 3'd3;
  localparam logic [2:0] ERR_ZERO_LEN = 3'd4;
  localparam logic [2:0] ERR_TOO_LONG = 3'd5;
  localparam logic [2:0] ERR_CHECKSUM = 3'd6;

  localparam logic REG_EXPECTED_ID = 1'b0;
  localparam logic REG_CAPACITY    = 1'b1;

  localparam logic [9:0] CAPACITY_RESET = 10'd64;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [2:0] code;
    logic [7:0] id;
    logic [7:0] status;
    logic [8:0] len;
  } verdict_t;

  typedef struct packed {
    logic [7:0] expected_id;
    logic [9:0] capacity;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[hdl/sspc_if.sv]
interface sspc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       start_req;

  modport source (output valid, output rx_byte, output start_req, input ready);
  modport sink   (input valid, input rx_byte, input start_req, output ready);
endinterface

interface sspc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] error_code;
  logic [7:0] reply_id;
  logic [7:0] status_byte;
  logic [8:0] readable_length;

  modport source (output valid, output error_code, output reply_id, output status_byte,
                  output readable_length, input ready);
  modport sink   (input valid, input error_code, input reply_id, input status_byte,
                  input readable_length, output ready);
endinterface

[hdl/sspc_front.sv]
module sspc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  sspc_pkg::cfg_t    cfg,
  input  sspc_pkg::q_stat_t q_stat,
  output logic              push,
  output sspc_pkg::verdict_t verdict,
  sspc_in_if.sink           in_chan
);
  import sspc_pkg::*;

  logic [8:0] pos_r, pos_nxt, pos_e;
  logic [7:0] sum_r, sum_nxt, sum_e;
  logic [7:0] len_r, len_nxt, len_e;
  logic [7:0] id_r, id_nxt, id_e;
  logic [7:0] stat_r, stat_nxt, stat_e;
  logic       fin_r, fin_nxt, fin_e;
  logic       accept;
  logic       emit;
  logic [2:0] code;
  logic [7:0] b;

  assign in_chan.ready = !q_stat.full;
  assign accept = in_chan.valid && in_chan.ready;
  assign b = in_chan.rx_byte;

  always_comb begin
    if (in_chan.start_req) begin
      pos_e  = '0;
      sum_e  = '0;
      len_e  = '0;
      id_e   = '0;
      stat_e = '0;
      fin_e  = 1'b0;
    end else begin
      pos_e  = pos_r;
      sum_e  = sum_r;
      len_e  = len_r;
      id_e   = id_r;
      stat_e = stat_r;
      fin_e  = fin_r;
    end
  end

  always_comb begin
    pos_nxt  = pos_e;
    sum_nxt  = sum_e;
    len_nxt  = len_e;
    id_nxt   = id_e;
    stat_nxt = stat_e;
    fin_nxt  = fin_e;
    emit     = 1'b0;
    code     = ERR_OK;
    if (!fin_e) begin
      if (pos_e < POS_ID) begin
        if (b != HDR_BYTE) begin
          emit = 1'b1;
          code = ERR_HEADER;
        end
      end else if (pos_e == POS_ID) begin
        id_nxt = b;
        if (b != cfg.expected_id) begin
          emit = 1'b1;
          code = ERR_ID_MISM;
        end else if (b == BAD_ID) begin
          emit = 1'b1;
          code = ERR_ID_BCAST;
        end else begin
          sum_nxt = sum_e + b;
        end
      end else if (pos_e == POS_LEN) begin
        len_nxt = b;
        if (b == 8'd0) begin
          emit = 1'b1;
          code = ERR_ZERO_LEN;
        end else if (({2'b00, b} + PKT_EXTRA) > cfg.capacity) begin
          emit = 1'b1;
          code = ERR_TOO_LONG;
        end else begin
          sum_nxt = sum_e + b;
        end
      end else begin
        if (pos_e == POS_STATUS) begin
          stat_nxt = b;
        end
        if (pos_e == ({1'b0, len_e} + LEN_EXTRA)) begin
          emit = 1'b1;
          code = ((~sum_e) == b) ? ERR_OK : ERR_CHECKSUM;
        end else begin
          sum_nxt = sum_e + b;
        end
      end
      if (emit) begin
        fin_nxt = 1'b1;
      end else begin
        pos_nxt = pos_e + 9'd1;
      end
    end
  end

  assign push           = accept && emit;
  assign verdict.code   = code;
  assign verdict.id     = id_nxt;
  assign verdict.status = stat_nxt;
  assign verdict.len    = {1'b0, len_nxt} + LEN_EXTRA;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      sum_r  <= '0;
      len_r  <= '0;
      id_r   <= '0;
      stat_r <= '0;
      fin_r  <= 1'b1;
    end else if (accept) begin
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      len_r  <= len_nxt;
      id_r   <= id_nxt;
      stat_r <= stat_nxt;
      fin_r  <= fin_nxt;
    end
  end

endmodule

[hdl/sspc_queue.sv]
module sspc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sspc_pkg::verdict_t wr_data,
  input  logic               pop,
  output sspc_pkg::verdict_t rd_data,
  output sspc_pkg::q_stat_t  q_stat
);
  import sspc_pkg::*;

  verdict_t        mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign q_stat.full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[hdl/sspc_back.sv]
module sspc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  sspc_pkg::q_stat_t  q_stat,
  input  sspc_pkg::verdict_t rd_data,
  output logic               pop,
  sspc_out_if.source         out_chan
);
  import sspc_pkg::*;

  logic       valid_r, valid_nxt;
  logic [2:0] code_r;
  logic [7:0] id_r;
  logic [7:0] stat_r;
  logic [8:0] len_r;
  logic       ok;

  assign pop = !q_stat.empty && (!valid_r || out_chan.ready);
  assign ok  = (rd_data.code == ERR_OK);

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      code_r <= rd_data.code;
      id_r   <= ok ? rd_data.id : FILL_BYTE;
      stat_r <= ok ? rd_data.status : FILL_BYTE;
      len_r  <= ok ? rd_data.len : 9'd0;
    end
  end

  assign out_chan.valid           = valid_r;
  assign out_chan.error_code      = code_r;
  assign out_chan.reply_id        = id_r;
  assign out_chan.status_byte     = stat_r;
  assign out_chan.readable_length = len_r;

endmodule

[hdl/servo_status_packet_checker_top.sv]
// Channel   Direction  Payload
// in_chan   sink       rx_byte[7:0], start_req
// out_chan  source     error_code[2:0], reply_id[7:0], status_byte[7:0], readable_length[8:0]
// cfg_*     APB slave  0x0 expected_id[7:0], 0x4 buffer_capacity[9:0]
//
// One byte per cycle if ready; a verdict reaches out_chan via the queue and output register.
// Parser state advances once per accepted byte; the four-entry verdict queue sets the slack.
// rst_n is synchronous: parser waits for start_req, queue and output register empty.
// in_chan.ready drops only while the verdict queue is full under an output stall.
module servo_status_packet_checker_top (
  input  logic        clk,
  input  logic        rst_n,
  sspc_in_if.sink     in_chan,
  sspc_out_if.source  out_chan,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import sspc_pkg::*;

  cfg_t     cfg_r;
  q_stat_t  q_stat;
  verdict_t wr_data;
  verdict_t rd_data;
  logic     push;
  logic     pop;
  logic     cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_id <= 8'd0;
      cfg_r.capacity    <= CAPACITY_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_EXPECTED_ID: cfg_r.expected_id <= cfg_pwdata[7:0];
        REG_CAPACITY:    cfg_r.capacity    <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_EXPECTED_ID: cfg_prdata = {24'd0, cfg_r.expected_id};
      REG_CAPACITY:    cfg_prdata = {22'd0, cfg_r.capacity};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  sspc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_stat  (q_stat),
    .push    (push),
    .verdict (wr_data),
    .in_chan (in_chan)
  );

  sspc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (wr_data),
    .pop     (pop),
    .rd_data (rd_data),
    .q_stat  (q_stat)
  );

  sspc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .rd_data  (rd_data),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

[sim/sspc_verdict_checker.sv]
`timescale 1ns / 100ps
module sspc_verdict_checker
  import sspc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_start_req,
  input  logic        out_valid,
  input  logic        out_ready,
  input  verdict_t    out_verdict,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          mismatches,
  output int          pending
);

  logic [7:0] want_id;
  logic [9:0] capacity;
  logic [8:0] pos;
  logic [7:0] sum;
  logic [7:0] len_fld;
  logic [7:0] seen_id;
  logic [7:0] seen_status;
  logic       waiting;
  int         fail_count = 0;
  verdict_t   verdicts_due[$];

  task automatic issue_verdict(input logic [2:0] code);
    verdict_t v;
    v.code = code;
    if (code == ERR_OK) begin
      v.id     = seen_id;
      v.status = seen_status;
      v.len    = {1'b0, len_fld} + LEN_EXTRA;
    end else begin
      v.id     = FILL_BYTE;
      v.status = FILL_BYTE;
      v.len    = '0;
    end
    verdicts_due.push_back(v);
    waiting = 1'b1;
  endtask

  task automatic judge_byte(input logic [7:0] b, input logic s);
    if (s) begin
      pos         = '0;
      sum         = '0;
      len_fld     = '0;
      seen_id     = '0;
      seen_status = '0;
      waiting     = 1'b0;
    end else if (waiting) begin
      return;
    end
    if (pos < POS_ID) begin
      if (b != HDR_BYTE) begin
        issue_verdict(ERR_HEADER);
        return;
      end
    end else if (pos == POS_ID) begin
      seen_id = b;
      if (b != want_id) begin
        issue_verdict(ERR_ID_MISM);
        return;
      end
      if (b == BAD_ID) begin
        issue_verdict(ERR_ID_BCAST);
        return;
      end
      sum = sum + b;
    end else if (pos == POS_LEN) begin
      len_fld = b;
      if (b == 8'd0) begin
        issue_verdict(ERR_ZERO_LEN);
        return;
      end
      if ({2'b00, b} + PKT_EXTRA > capacity) begin
        issue_verdict(ERR_TOO_LONG);
        return;
      end
      sum = sum + b;
    end else begin
      if (pos == POS_STATUS) seen_status = b;
      if (pos == {1'b0, len_fld} + LEN_EXTRA) begin
        issue_verdict((8'(~sum) == b) ? ERR_OK : ERR_CHECKSUM);
        return;
      end
      sum = sum + b;
    end
    pos = pos + 9'd1;
  endtask

  always @(posedge clk) begin
    verdict_t due;
    if (!rst_n) begin
      want_id     = 8'd0;
      capacity    = CAPACITY_RESET;
      pos         = '0;
      sum         = '0;
      len_fld     = '0;
      seen_id     = '0;
      seen_status = '0;
      waiting     = 1'b1;
      verdicts_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_EXPECTED_ID) want_id = cfg_pwdata[7:0];
        else capacity = cfg_pwdata[9:0];
      end
      if (in_valid && in_ready) judge_byte(in_rx_byte, in_start_req);
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected verdict at %0t: code %0d id %02h status %02h len %0d",
                     $time, out_verdict.code, out_verdict.id, out_verdict.status,
                     out_verdict.len);
        end else begin
          due = verdicts_due.pop_front();
          if (out_verdict.code !== due.code || out_verdict.id !== due.id ||
              out_verdict.status !== due.status || out_verdict.len !== due.len) begin
            fail_count++;
            if (fail_count <= 10)
              $display("verdict mismatch at %0t: expected code %0d id %02h status %02h len %0d, %s",
                       $time, due.code, due.id, due.status, due.len,
                       $sformatf("got code %0d id %02h status %02h len %0d",
                                 out_verdict.code, out_verdict.id, out_verdict.status,
                                 out_verdict.len));
          end
        end
      end
    end
    mismatches <= fail_count;
    pending    <= verdicts_due.size();
  end

endmodule

[sim/tb_servo_status_packet_checker_top.sv]
`timescale 1ns / 100ps
module tb_servo_status_packet_checker_top;
  import sspc_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;

  typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_BURSTY} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int       mismatches;
  int       pending;
  int       sent = 0;
  int       burst_left = 0;
  int       idle_cycles = 0;
  rx_mode_t rx_mode = RX_STREAM;
  int       mode_left = 0;
  int       stall_left = 0;

  sspc_in_if  in_chan ();
  sspc_out_if out_chan ();

  servo_status_packet_checker_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  sspc_verdict_checker verdict_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .in_rx_byte   (in_chan.rx_byte),
    .in_start_req (in_chan.start_req),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_verdict  ({out_chan.error_code, out_chan.reply_id, out_chan.status_byte,
                    out_chan.readable_length}),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_pready   (cfg_pready),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      rx_mode   = rx_mode_t'($urandom_range(0, 2));
      mode_left = $urandom_range(20, 200);
    end
    mode_left--;
    case (rx_mode)
      RX_STREAM: begin
        out_chan.ready <= 1'b1;
      end
      RX_COIN: begin
        out_chan.ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_chan.ready <= 1'b0;
        end else begin
          out_chan.ready <= 1'b1;
          if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_psel && cfg_penable && cfg_pready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_regs(input logic [7:0] id, input logic [9:0] cap);
    apb_write({REG_EXPECTED_ID, 2'b00}, {24'd0, id});
    apb_write({REG_CAPACITY, 2'b00}, {22'd0, cap});
  endtask

  // hold valid across a burst; drop it only for a gap
  task automatic send_byte(input logic [7:0] b, input logic s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_chan.valid     <= 1'b0;
        in_chan.rx_byte   <= 8'($urandom);
        in_chan.start_req <= 1'($urandom_range(0, 1));
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_chan.valid     <= 1'b1;
    in_chan.rx_byte   <= b;
    in_chan.start_req <= s;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_head(input logic [7:0] id, input logic [7:0] len);
    send_byte(HDR_BYTE, 1'b1);
    send_byte(HDR_BYTE, 1'b0);
    send_byte(id, 1'b0);
    send_byte(len, 1'b0);
  endtask

  task automatic send_reply(input logic [7:0] id, input logic [7:0] len, input bit spoil);
    logic [7:0] sum;
    logic [7:0] pay;
    sum = id + len;
    send_head(id, len);
    for (int k = 1; k < len; k++) begin
      pay = 8'($urandom);
      sum = sum + pay;
      send_byte(pay, 1'b0);
    end
    if (spoil) send_byte(~sum ^ 8'($urandom_range(1, 255)), 1'b0);
    else send_byte(~sum, 1'b0);
  endtask

  // drop valid, wait out every verdict, then let the pipeline drain
  task automatic settle();
    in_chan.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input logic [7:0] id, input logic [9:0] cap, input bit jumbo,
                           input int quota);
    int first;
    int pick;
    int max_len;
    int lim;
    set_regs(id, cap);
    first = sent;
    if (cap >= 10'd259) max_len = 255;
    else if (cap >= 10'd5) max_len = int'(cap) - 4;
    else max_len = 1;
    lim = (max_len < 12) ? max_len : 12;
    if (jumbo) send_reply(id, 8'(max_len), 1'b0);
    while (sent - first < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 29) == 0)
          send_reply(id, 8'(max_len), $urandom_range(0, 6) == 0);
        else
          send_reply(id, 8'($urandom_range(1, lim)), $urandom_range(0, 6) == 0);
      end else if (pick < 76) begin
        send_byte(HDR_BYTE, 1'b1);
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom), 1'b0);
      end else if (pick < 81) begin
        send_reply(8'($urandom), 8'($urandom_range(1, lim)), 1'b0);
      end else if (pick < 85) begin
        send_head(id, 8'd0);
      end else if (pick < 90) begin
        send_head(id, 8'($urandom));
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
      end else if (pick < 94) begin
        if ($urandom_range(0, 1) == 0) begin
          send_byte(8'($urandom), 1'b1);
        end else begin
          send_byte(HDR_BYTE, 1'b1);
          send_byte(8'($urandom_range(0, 254)), 1'b0);
        end
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end
    end
    settle();
  endtask

  initial begin
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.rx_byte   = 8'd0;
    in_chan.start_req = 1'b0;
    out_chan.ready    = 1'b0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_byte(8'h5A, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(HDR_BYTE, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(HDR_BYTE, 1'b1);
    send_byte(HDR_BYTE, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(HDR_BYTE, 1'b0);
    send_head(8'h00, 8'd0);
    send_head(8'h00, 8'd61);
    send_byte(HDR_BYTE, 1'b1);
    send_byte(HDR_BYTE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_reply(8'h00, 8'd1, 1'b0);
    send_reply(8'h00, 8'd2, 1'b1);
    settle();
    set_regs(8'hFF, 10'd0);
    send_byte(HDR_BYTE, 1'b1);
    send_byte(HDR_BYTE, 1'b0);
    send_byte(8'hFF, 1'b0);
    settle();

    run_phase(8'h01, 10'd259, 1'b1, 260);
    run_phase(8'h00, 10'd5, 1'b0, 50);
    run_phase(8'($urandom), 10'($urandom_range(5, 300)), 1'b0, 70);
    run_phase(8'hFE, 10'd512, 1'b0, 70);
    run_phase(8'hFF, 10'($urandom_range(0, 512)), 1'b0, 45);
    run_phase(8'($urandom), 10'd4, 1'b0, 45);
    run_phase(8'($urandom), 10'($urandom_range(16, 64)), 1'b0, 70);
    run_phase(8'h80, 10'd0, 1'b0, 30);
    run_phase(8'h7F, 10'd511, 1'b0, 70);

    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
